// ----- hdl/wtent_pkg.sv -----
// ----------------------------------------------------------------------------
// wtent_pkg
// Shared types, codes and the natural-log table helper for the windowed
// tuple entropy block.
// ----------------------------------------------------------------------------
package wtent_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WINDOW = 2'd0,
    CFG_STEP   = 2'd1,
    CFG_MASK   = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned CODES_W     = 64;
  localparam int unsigned LANE_STRIDE = 8;
  localparam int unsigned ENT_W       = 19;
  // ln(n) in Q16 for n up to 256 fits in 19 bits
  localparam int unsigned LN_W        = 19;

  localparam logic [LEN_W-1:0]  WINDOW_RESET = 7'd12;
  localparam logic [LEN_W-1:0]  STEP_RESET   = 7'd12;
  localparam logic [MASK_W-1:0] MASK_RESET   = 8'hFF;

  // one-hot sequencer states
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RDI  = 9'b000000010,
    S_LDI  = 9'b000000100,
    S_CMP  = 9'b000001000,
    S_ACC  = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_NUM  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  // ln(n) * 65536 rounded to nearest; only ever evaluated on constants
  function automatic int unsigned ln_q16(int unsigned n);
    real r;
    r = 0.0;
    if (n > 1) begin
      r = $ln(real'(n)) * 65536.0 + 0.5;
    end
    return int'($floor(r));
  endfunction

endpackage

// ----- hdl/wtent_ram.sv -----
// ----------------------------------------------------------------------------
// wtent_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module wtent_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/windowed_tuple_entropy.sv -----
// ----------------------------------------------------------------------------
// windowed_tuple_entropy
// Sliding-window Shannon entropy of masked feature tuples.
// ----------------------------------------------------------------------------
// Input channel: one beat per sequence position (feature codes plus a
// sequence-start flag). The masked tuple is written into a ring RAM.
// When a beat completes a window (windows start every step_length positions
// from sequence start), the block scans the window in the ring: for each
// entry it reads the entry, then re-reads all W entries to count matches,
// adds ln(count) from a Q16 table, then forms W*ln(W) - sum and divides by W
// with a restoring divider, one quotient bit per cycle.
// A beat that closes no window is accepted without a stall. A beat that closes
// a window keeps in_stall_o high while the block scans (RDI, LDI, then CMP over
// the window and ACC per scanned entry), multiplies, forms the numerator,
// divides and loads the result, longer while a held result still occupies the
// output register; the single RAM read port sets the scan length.
// Output channel: one entropy beat per closed window, held in an output
// register. While the receiver stalls, the block keeps accepting beats until one
// closes a window, scans it and only waits before loading the new result into the occupied register.
// Config port: cfg_ready_o is always high; write only while idle.
// Reset: state, position counters, ring head, output valid and config registers
// return to defaults; ring contents are left as is (only written entries are counted).
// ----------------------------------------------------------------------------
module windowed_tuple_entropy #(
  parameter int unsigned MAX_WINDOW   = 64,
  parameter int unsigned NUM_FEATURES = 8,
  parameter int unsigned CODE_BITS    = 8,
  parameter int unsigned POS_BITS     = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wtent_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wtent_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [wtent_pkg::CODES_W-1:0]       feature_codes_i,
  input  logic                                sequence_start_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [wtent_pkg::ENT_W-1:0]         window_entropy_o,
  output logic [POS_BITS-1:0]                 window_start_pos_o
);

  localparam int unsigned AW    = $clog2(MAX_WINDOW);
  localparam int unsigned WW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SW    = WW + 1;
  localparam int unsigned TUP_W = NUM_FEATURES * CODE_BITS;
  localparam int unsigned LN_W  = wtent_pkg::LN_W;
  localparam int unsigned NUM_W = LN_W + WW;
  localparam int unsigned DCW   = $clog2(NUM_W + 1);

  // configuration
  logic [wtent_pkg::LEN_W-1:0]  win_q, step_q;
  logic [wtent_pkg::MASK_W-1:0] mask_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= wtent_pkg::WINDOW_RESET;
      step_q <= wtent_pkg::STEP_RESET;
      mask_q <= wtent_pkg::MASK_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wtent_pkg::CFG_WINDOW: win_q  <= cfg_data_i[wtent_pkg::LEN_W-1:0];
        wtent_pkg::CFG_STEP:   step_q <= cfg_data_i[wtent_pkg::LEN_W-1:0];
        wtent_pkg::CFG_MASK:   mask_q <= cfg_data_i[wtent_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // effective window and step
  logic [WW-1:0]       w_eff;
  logic [POS_BITS-1:0] step_eff;

  always_comb begin
    if (win_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(win_q) > 32'(MAX_WINDOW)) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(win_q);
    end
    step_eff = (step_q == '0) ? POS_BITS'(1) : POS_BITS'(step_q);
  end

  // Q16 log table, folded to constants
  logic [LN_W-1:0] ln_tab [MAX_WINDOW + 1];

  always_comb begin
    for (int n = 0; n <= MAX_WINDOW; n++) begin
      ln_tab[n] = LN_W'(wtent_pkg::ln_q16(n));
    end
  end

  // tuple packing
  logic [TUP_W-1:0] tuple;

  always_comb begin
    for (int k = 0; k < NUM_FEATURES; k++) begin
      tuple[k*CODE_BITS +: CODE_BITS] = mask_q[k] ?
          feature_codes_i[k*wtent_pkg::LANE_STRIDE +: CODE_BITS] : '0;
    end
  end

  // sequencer state
  wtent_pkg::state_e state_q, state_d;
  logic [POS_BITS-1:0] pos_q, pos_d, nws_q, nws_d, wstart_q, wstart_d;
  logic [AW-1:0]       head_q, head_d, base_q, base_d;
  logic [WW-1:0]       w_q, w_d, i_q, i_d, j_q, j_d, cnt_q, cnt_d;
  logic [TUP_W-1:0]    ti_q, ti_d;
  logic [NUM_W-1:0]    sum_q, sum_d, prod_q, prod_d, dn_q, dn_d;
  logic [WW-1:0]       rem_q, rem_d;
  logic [DCW-1:0]      dcnt_q, dcnt_d;
  logic                out_valid_q, out_valid_d;
  logic [wtent_pkg::ENT_W-1:0] ent_q, ent_d;
  logic [POS_BITS-1:0] opos_q, opos_d;

  logic                in_acc;
  logic [POS_BITS-1:0] pos_eff, nws_eff, pos_gap;
  logic                emit;
  logic [SW-1:0]       base_sum, rd_sum;
  logic [WW-1:0]       rd_off;
  logic [AW-1:0]       ram_raddr;
  logic [TUP_W-1:0]    ram_rdata;
  logic                out_free;
  logic [SW-1:0]       rem_t;
  logic                rem_ge;

  assign in_stall_o = (state_q != wtent_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign pos_eff = sequence_start_i ? '0 : pos_q;
  assign nws_eff = sequence_start_i ? '0 : nws_q;
  assign pos_gap = pos_eff - nws_eff;
  assign emit    = (pos_gap >= POS_BITS'(w_eff - WW'(1))) &&
                   (pos_gap < POS_BITS'(MAX_WINDOW));

  // ring index of the window's first entry: head - gap, modulo the depth
  always_comb begin
    base_sum = SW'(head_q) + SW'(MAX_WINDOW) - SW'(pos_gap[WW-1:0]);
    if (base_sum >= SW'(MAX_WINDOW)) begin
      base_sum = base_sum - SW'(MAX_WINDOW);
    end
  end

  // read address: base + offset, modulo the depth
  always_comb begin
    unique case (state_q)
      wtent_pkg::S_RDI: rd_off = i_q;
      wtent_pkg::S_CMP: rd_off = j_q;
      default:          rd_off = '0;
    endcase
    rd_sum = SW'(base_q) + SW'(rd_off);
    if (rd_sum >= SW'(MAX_WINDOW)) begin
      rd_sum = rd_sum - SW'(MAX_WINDOW);
    end
    ram_raddr = rd_sum[AW-1:0];
  end

  wtent_ram #(
    .WIDTH (TUP_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (head_q),
    .wdata_i (tuple),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // divider step
  assign rem_t  = {rem_q, dn_q[NUM_W-1]};
  assign rem_ge = rem_t >= SW'(w_q);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    nws_d       = nws_q;
    wstart_d    = wstart_q;
    head_d      = head_q;
    base_d      = base_q;
    w_d         = w_q;
    i_d         = i_q;
    j_d         = j_q;
    cnt_d       = cnt_q;
    ti_d        = ti_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    dn_d        = dn_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    ent_d       = ent_q;
    opos_d      = opos_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      wtent_pkg::S_IDLE: begin
        if (in_acc) begin
          pos_d  = pos_eff + POS_BITS'(1);
          head_d = (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
          nws_d  = nws_eff;
          if (emit) begin
            nws_d    = nws_eff + step_eff;
            wstart_d = nws_eff;
            base_d   = base_sum[AW-1:0];
            w_d      = w_eff;
            i_d      = '0;
            sum_d    = '0;
            state_d  = wtent_pkg::S_RDI;
          end
        end
      end
      wtent_pkg::S_RDI: begin
        state_d = wtent_pkg::S_LDI;
      end
      wtent_pkg::S_LDI: begin
        ti_d    = ram_rdata;
        j_d     = WW'(1);
        cnt_d   = '0;
        state_d = wtent_pkg::S_CMP;
      end
      wtent_pkg::S_CMP: begin
        // data for offset j-1 arrives while offset j is issued
        cnt_d = cnt_q + WW'(ram_rdata == ti_q);
        if (j_q < w_q) begin
          j_d = j_q + WW'(1);
        end else begin
          state_d = wtent_pkg::S_ACC;
        end
      end
      wtent_pkg::S_ACC: begin
        sum_d = sum_q + NUM_W'(ln_tab[cnt_q]);
        i_d   = i_q + WW'(1);
        if (SW'(i_q) + SW'(1) == SW'(w_q)) begin
          state_d = wtent_pkg::S_MUL;
        end else begin
          state_d = wtent_pkg::S_RDI;
        end
      end
      wtent_pkg::S_MUL: begin
        prod_d  = NUM_W'(w_q) * NUM_W'(ln_tab[w_q]);
        state_d = wtent_pkg::S_NUM;
      end
      wtent_pkg::S_NUM: begin
        dn_d    = prod_q - sum_q + NUM_W'(w_q >> 1);
        rem_d   = '0;
        dcnt_d  = DCW'(NUM_W);
        state_d = wtent_pkg::S_DIV;
      end
      wtent_pkg::S_DIV: begin
        rem_d  = rem_ge ? WW'(rem_t - SW'(w_q)) : WW'(rem_t);
        dn_d   = {dn_q[NUM_W-2:0], rem_ge};
        dcnt_d = dcnt_q - DCW'(1);
        if (dcnt_q == DCW'(1)) begin
          state_d = wtent_pkg::S_OUT;
        end
      end
      wtent_pkg::S_OUT: begin
        if (out_free) begin
          ent_d       = dn_q[wtent_pkg::ENT_W-1:0];
          opos_d      = wstart_q;
          out_valid_d = 1'b1;
          state_d     = wtent_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wtent_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wtent_pkg::S_IDLE;
      pos_q       <= '0;
      nws_q       <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      nws_q       <= nws_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wstart_q <= wstart_d;
    base_q   <= base_d;
    w_q      <= w_d;
    i_q      <= i_d;
    j_q      <= j_d;
    cnt_q    <= cnt_d;
    ti_q     <= ti_d;
    sum_q    <= sum_d;
    prod_q   <= prod_d;
    dn_q     <= dn_d;
    rem_q    <= rem_d;
    dcnt_q   <= dcnt_d;
    ent_q    <= ent_d;
    opos_q   <= opos_d;
  end

  assign out_valid_o        = out_valid_q;
  assign window_entropy_o   = ent_q;
  assign window_start_pos_o = opos_q;

  // every entry matches at least itself and at most the whole window
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wtent_pkg::S_ACC) |-> (cnt_q >= WW'(1) && cnt_q <= w_q))
    else $error("match count out of range");

  // ring is never written during a scan
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != wtent_pkg::S_IDLE) |=> (state_q != wtent_pkg::S_IDLE) || !in_acc ||
    $past(state_q == wtent_pkg::S_OUT))
    else $error("ring write while scanning");

  // read address stays inside the ring
  a_raddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wtent_pkg::S_RDI || state_q == wtent_pkg::S_CMP) |->
    (32'(ram_raddr) < 32'(MAX_WINDOW)))
    else $error("ring read address out of range");

  // a result is loaded only into a free output register
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wtent_pkg::S_OUT && out_valid_q && out_stall_i) |=> $stable(ent_q))
    else $error("result overwritten while held");

endmodule
